// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define BFX_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset cycles included.
`define BFX_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/bfx_pkg.sv -----
`default_nettype none

package bfx_pkg;

  // Field widths of the channel words
  localparam int CODE_W   = 3;
  localparam int ARG_A_W  = 16;
  localparam int ARG_B_W  = 8;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int PC_OUT_W = 13;

  // Item kinds
  localparam logic OPC_LOAD = 1'b0;
  localparam logic OPC_STEP = 1'b1;

  // IR operation codes
  localparam logic [CODE_W-1:0] IR_ADD   = 3'd0;
  localparam logic [CODE_W-1:0] IR_MUL   = 3'd1;
  localparam logic [CODE_W-1:0] IR_CONST = 3'd2;
  localparam logic [CODE_W-1:0] IR_MOVE  = 3'd3;
  localparam logic [CODE_W-1:0] IR_IN    = 3'd4;
  localparam logic [CODE_W-1:0] IR_OUT   = 3'd5;
  localparam logic [CODE_W-1:0] IR_LOOP  = 3'd6;
  localparam logic [CODE_W-1:0] IR_END   = 3'd7;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_EXEC = 2'd0;
  localparam logic [STATUS_W-1:0] ST_HALT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LOAD = 2'd2;

  // One stored instruction
  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [ARG_A_W-1:0] a;
    logic [ARG_B_W-1:0] b;
  } insn_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic clear;
    logic exec;
    logic mod_mul;
    logic mod_sub;
    logic mod_fix;
    logic mul_rd;
    logic mul_wb;
    logic jump;
    logic send;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic              clr_done;
    logic              is_step;
    logic              past_end;
    logic              jump;
    logic [CODE_W-1:0] code;
  } stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bfx_if.sv -----
`default_nettype none

// Input channel: one word per load or step item
interface bfx_in_if;
  logic                                valid;
  logic                                ready;
  logic                                opcode;
  logic [bfx_pkg::CODE_W-1:0]          ir_code;
  logic signed [bfx_pkg::ARG_A_W-1:0]  arg_a;
  logic signed [bfx_pkg::ARG_B_W-1:0]  arg_b;
  logic [bfx_pkg::BYTE_W-1:0]          in_byte;

  modport source (output valid, opcode, ir_code, arg_a, arg_b, in_byte, input ready);
  modport sink   (input valid, opcode, ir_code, arg_a, arg_b, in_byte, output ready);
endinterface

// Result channel: one word per item
interface bfx_out_if;
  logic                             valid;
  logic                             ready;
  logic [bfx_pkg::STATUS_W-1:0]     status;
  logic                             out_valid;
  logic [bfx_pkg::BYTE_W-1:0]       out_byte;
  logic [bfx_pkg::PC_OUT_W-1:0]     pc_now;

  modport source (output valid, status, out_valid, out_byte, pc_now, input ready);
  modport sink   (input valid, status, out_valid, out_byte, pc_now, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bfx_ram.sv -----
`default_nettype none

// Simple dual-port RAM: one write port, one registered read port.
module bfx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and registered read of the addressed word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bfx_ctrl.sv -----
`default_nettype none

// Sequencer: after the reset clear, walks one item through capture, execute, modulo,
// write-back or jump, and result hand-off, and owns both channel handshakes.
module bfx_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire bfx_pkg::stat_t stat,
  output bfx_pkg::cmd_t       cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_EXEC  = 4'd2;
  localparam logic [3:0] S_MOD1  = 4'd3;
  localparam logic [3:0] S_MOD2  = 4'd4;
  localparam logic [3:0] S_MOD3  = 4'd5;
  localparam logic [3:0] S_MULRD = 4'd6;
  localparam logic [3:0] S_MULWB = 4'd7;
  localparam logic [3:0] S_JUMP  = 4'd8;
  localparam logic [3:0] S_RESP  = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       out_vld_r, out_vld_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_vld_r;

  // Next state and commands
  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    out_vld_nxt = out_vld_r && !out_ready;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        priority if (!stat.is_step || stat.past_end) begin
          state_nxt = S_RESP;
        end else if (stat.code == bfx_pkg::IR_MOVE || stat.code == bfx_pkg::IR_MUL) begin
          state_nxt = S_MOD1;
        end else if (stat.jump) begin
          state_nxt = S_JUMP;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_MOD1: begin
        cmd.mod_mul = 1'b1;
        state_nxt   = S_MOD2;
      end
      S_MOD2: begin
        cmd.mod_sub = 1'b1;
        state_nxt   = S_MOD3;
      end
      S_MOD3: begin
        cmd.mod_fix = 1'b1;
        state_nxt   = (stat.code == bfx_pkg::IR_MOVE) ? S_RESP : S_MULRD;
      end
      S_MULRD: begin
        cmd.mul_rd = 1'b1;
        state_nxt  = S_MULWB;
      end
      S_MULWB: begin
        cmd.mul_wb = 1'b1;
        state_nxt  = S_RESP;
      end
      S_JUMP: begin
        cmd.jump  = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        // Hand the word to the output register once it is free
        if (!out_vld_r || out_ready) begin
          cmd.send    = 1'b1;
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bfx_datapath.sv -----
`default_nettype none

// Datapath: program store, loop tables, data memory, pointer and counter
// registers, the constant-reciprocal modulo for pointer arithmetic, and the
// result registers.
module bfx_datapath #(
  parameter int MEM_DEPTH  = 32768,
  parameter int PROG_DEPTH = 4096,
  parameter int LOOP_DEPTH = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire bfx_pkg::cmd_t                   cmd,
  output bfx_pkg::stat_t                       stat,
  input  wire logic                            pl_opcode,
  input  wire logic [bfx_pkg::CODE_W-1:0]      pl_ir_code,
  input  wire logic [bfx_pkg::ARG_A_W-1:0]     pl_arg_a,
  input  wire logic [bfx_pkg::ARG_B_W-1:0]     pl_arg_b,
  input  wire logic [bfx_pkg::BYTE_W-1:0]      pl_in_byte,
  output logic      [bfx_pkg::STATUS_W-1:0]    pl_status,
  output logic                                 pl_out_valid,
  output logic      [bfx_pkg::BYTE_W-1:0]      pl_out_byte,
  output logic      [bfx_pkg::PC_OUT_W-1:0]    pl_pc_now
);

  localparam int AW = $clog2(MEM_DEPTH);
  localparam int IW = $clog2(PROG_DEPTH);
  localparam int PW = $clog2(PROG_DEPTH + 1);
  localparam int LW = $clog2(LOOP_DEPTH);
  localparam int AAW = bfx_pkg::ARG_A_W;
  localparam int BW  = bfx_pkg::BYTE_W;
  // Biased pointer sum stays non-negative and below 2*MEM_DEPTH + 2**AAW
  localparam int SW   = $clog2(2 * MEM_DEPTH + 2 ** AAW);
  localparam int BIAS = MEM_DEPTH * ((2 ** (AAW - 1) + MEM_DEPTH - 1) / MEM_DEPTH);
  localparam logic [SW-1:0] M_C    = SW'(MEM_DEPTH);
  localparam logic [SW-1:0] BIAS_C = SW'(BIAS);
  localparam logic [SW:0]   RECIP_C = (SW + 1)'((64'(1) << SW) / MEM_DEPTH);
  localparam int IWD = $bits(bfx_pkg::insn_t);

  function automatic logic id_ok(input logic [AAW-1:0] id);
    id_ok = {1'b0, id} < (AAW + 1)'(LOOP_DEPTH);
  endfunction

  // Captured input word
  logic             cap_step_r, cap_step_nxt;
  logic [2:0]       cap_code_r, cap_code_nxt;
  logic [AAW-1:0]   cap_a_r, cap_a_nxt;
  logic [7:0]       cap_b_r, cap_b_nxt;
  logic [BW-1:0]    cap_byte_r, cap_byte_nxt;

  // Architectural state
  logic [PW-1:0]    len_r, len_nxt;
  logic [PW-1:0]    pc_r, pc_nxt;
  logic [AW-1:0]    dp_r, dp_nxt;
  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;

  // Work registers
  logic [BW-1:0]    cur_r, cur_nxt;
  logic [SW-1:0]    s_r, s_nxt;
  logic [SW-1:0]    q_r, q_nxt;
  logic [SW-1:0]    rraw_r, rraw_nxt;
  logic [AW-1:0]    madr_r, madr_nxt;

  // Pending result and output word
  logic [1:0]       res_status_r, res_status_nxt;
  logic             res_ov_r, res_ov_nxt;
  logic [BW-1:0]    res_ob_r, res_ob_nxt;
  logic [1:0]       o_status_r, o_status_nxt;
  logic             o_ov_r, o_ov_nxt;
  logic [BW-1:0]    o_ob_r, o_ob_nxt;
  logic [bfx_pkg::PC_OUT_W-1:0] o_pc_r, o_pc_nxt;

  // Memory ports
  logic             dm_we;
  logic [AW-1:0]    dm_waddr, dm_raddr;
  logic [BW-1:0]    dm_wdata, dm_rdata;
  logic             pg_we;
  logic [IWD-1:0]   pg_rdata;
  logic             ls_we, le_we;
  logic [IW-1:0]    ls_rdata, le_rdata;

  bfx_pkg::insn_t   insn;
  bfx_pkg::insn_t   ld_insn;
  logic             past_end;
  logic             jump;
  logic [2*SW:0]    prod;
  logic [2*SW-1:0]  qm;
  logic [SW-1:0]    rfix;
  logic [15:0]      mulp;

  assign insn     = bfx_pkg::insn_t'(pg_rdata);
  assign ld_insn  = '{code: cap_code_r, a: cap_a_r, b: cap_b_r};
  assign past_end = (pc_r >= len_r);
  assign jump     = ((insn.code == bfx_pkg::IR_LOOP) && (dm_rdata == '0) && id_ok(insn.a)) ||
                    ((insn.code == bfx_pkg::IR_END) && id_ok(insn.a));
  assign prod     = (2 * SW + 1)'(s_r) * (2 * SW + 1)'(RECIP_C);
  assign qm       = (2 * SW)'(q_r) * (2 * SW)'(M_C);
  assign rfix     = (rraw_r >= M_C) ? (rraw_r - M_C) : rraw_r;
  assign mulp     = 16'(insn.b) * 16'(cur_r);

  assign stat.clr_done = (clr_addr_r == AW'(MEM_DEPTH - 1));
  assign stat.is_step  = (cap_step_r == bfx_pkg::OPC_STEP);
  assign stat.past_end = past_end;
  assign stat.jump     = jump;
  assign stat.code     = insn.code;

  assign pl_status    = o_status_r;
  assign pl_out_valid = o_ov_r;
  assign pl_out_byte  = o_ob_r;
  assign pl_pc_now    = o_pc_r;

  // Program store and loop tables
  bfx_ram #(.WIDTH(IWD), .DEPTH(PROG_DEPTH)) u_prog (
    .clk   (clk),
    .we    (pg_we),
    .waddr (len_r[IW-1:0]),
    .wdata (ld_insn),
    .raddr (pc_r[IW-1:0]),
    .rdata (pg_rdata)
  );

  bfx_ram #(.WIDTH(IW), .DEPTH(LOOP_DEPTH)) u_loop_start (
    .clk   (clk),
    .we    (ls_we),
    .waddr (cap_a_r[LW-1:0]),
    .wdata (len_r[IW-1:0]),
    .raddr (insn.a[LW-1:0]),
    .rdata (ls_rdata)
  );

  bfx_ram #(.WIDTH(IW), .DEPTH(LOOP_DEPTH)) u_loop_end (
    .clk   (clk),
    .we    (le_we),
    .waddr (cap_a_r[LW-1:0]),
    .wdata (len_r[IW-1:0]),
    .raddr (insn.a[LW-1:0]),
    .rdata (le_rdata)
  );

  // Data memory
  bfx_ram #(.WIDTH(BW), .DEPTH(MEM_DEPTH)) u_data (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .raddr (dm_raddr),
    .rdata (dm_rdata)
  );

  // Per-command updates
  always_comb begin
    cap_step_nxt   = cap_step_r;
    cap_code_nxt   = cap_code_r;
    cap_a_nxt      = cap_a_r;
    cap_b_nxt      = cap_b_r;
    cap_byte_nxt   = cap_byte_r;
    len_nxt        = len_r;
    pc_nxt         = pc_r;
    dp_nxt         = dp_r;
    clr_addr_nxt   = clr_addr_r;
    cur_nxt        = cur_r;
    s_nxt          = s_r;
    q_nxt          = q_r;
    rraw_nxt       = rraw_r;
    madr_nxt       = madr_r;
    res_status_nxt = res_status_r;
    res_ov_nxt     = res_ov_r;
    res_ob_nxt     = res_ob_r;
    o_status_nxt   = o_status_r;
    o_ov_nxt       = o_ov_r;
    o_ob_nxt       = o_ob_r;
    o_pc_nxt       = o_pc_r;
    dm_we          = 1'b0;
    dm_waddr       = dp_r;
    dm_wdata       = '0;
    dm_raddr       = cmd.mul_rd ? madr_r : dp_r;
    pg_we          = 1'b0;
    ls_we          = 1'b0;
    le_we          = 1'b0;

    // Latch the accepted word
    if (cmd.capture) begin
      cap_step_nxt = pl_opcode;
      cap_code_nxt = pl_ir_code;
      cap_a_nxt    = pl_arg_a;
      cap_b_nxt    = pl_arg_b;
      cap_byte_nxt = pl_in_byte;
    end

    // Sweep zeros through the data memory after reset
    if (cmd.clear) begin
      dm_we        = 1'b1;
      dm_waddr     = clr_addr_r;
      clr_addr_nxt = clr_addr_r + AW'(1);
    end

    // Load or first step of an instruction
    if (cmd.exec) begin
      res_ov_nxt = 1'b0;
      res_ob_nxt = '0;
      if (cap_step_r == bfx_pkg::OPC_LOAD) begin
        res_status_nxt = bfx_pkg::ST_LOAD;
        if (len_r < PW'(PROG_DEPTH)) begin
          pg_we   = 1'b1;
          ls_we   = (cap_code_r == bfx_pkg::IR_LOOP) && id_ok(cap_a_r);
          le_we   = (cap_code_r == bfx_pkg::IR_END) && id_ok(cap_a_r);
          len_nxt = len_r + PW'(1);
        end
      end else if (past_end) begin
        res_status_nxt = bfx_pkg::ST_HALT;
      end else begin
        res_status_nxt = bfx_pkg::ST_EXEC;
        unique case (insn.code)
          bfx_pkg::IR_ADD: begin
            dm_we    = 1'b1;
            dm_wdata = dm_rdata + insn.a[BW-1:0];
            pc_nxt   = pc_r + PW'(1);
          end
          bfx_pkg::IR_CONST: begin
            dm_we    = 1'b1;
            dm_wdata = insn.a[BW-1:0];
            pc_nxt   = pc_r + PW'(1);
          end
          bfx_pkg::IR_IN: begin
            dm_we    = 1'b1;
            dm_wdata = cap_byte_r;
            pc_nxt   = pc_r + PW'(1);
          end
          bfx_pkg::IR_OUT: begin
            res_ov_nxt = 1'b1;
            res_ob_nxt = dm_rdata;
            pc_nxt     = pc_r + PW'(1);
          end
          bfx_pkg::IR_MOVE, bfx_pkg::IR_MUL: begin
            cur_nxt = dm_rdata;
            s_nxt   = SW'(dp_r) + {{(SW - AAW){insn.a[AAW-1]}}, insn.a} + BIAS_C;
          end
          bfx_pkg::IR_LOOP, bfx_pkg::IR_END: begin
            if (!jump) begin
              pc_nxt = pc_r + PW'(1);
            end
          end
          default: begin
            pc_nxt = pc_r + PW'(1);
          end
        endcase
      end
    end

    // Modulo by the memory size: estimate quotient, subtract, correct once
    if (cmd.mod_mul) begin
      q_nxt = prod[SW +: SW];
    end
    if (cmd.mod_sub) begin
      rraw_nxt = s_r - qm[SW-1:0];
    end
    if (cmd.mod_fix) begin
      if (insn.code == bfx_pkg::IR_MOVE) begin
        dp_nxt = rfix[AW-1:0];
        pc_nxt = pc_r + PW'(1);
      end else begin
        madr_nxt = rfix[AW-1:0];
      end
    end

    // Accumulate into the offset cell
    if (cmd.mul_wb) begin
      dm_we    = 1'b1;
      dm_waddr = madr_r;
      dm_wdata = dm_rdata + mulp[BW-1:0];
      pc_nxt   = pc_r + PW'(1);
    end

    // Take the branch through a loop table
    if (cmd.jump) begin
      pc_nxt = (insn.code == bfx_pkg::IR_LOOP) ? (PW'(le_rdata) + PW'(1)) : PW'(ls_rdata);
    end

    // Move the pending result into the output register
    if (cmd.send) begin
      o_status_nxt = res_status_r;
      o_ov_nxt     = res_ov_r;
      o_ob_nxt     = res_ob_r;
      o_pc_nxt     = bfx_pkg::PC_OUT_W'(pc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      pc_r       <= '0;
      dp_r       <= '0;
      clr_addr_r <= '0;
    end else begin
      len_r      <= len_nxt;
      pc_r       <= pc_nxt;
      dp_r       <= dp_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cap_step_r   <= cap_step_nxt;
    cap_code_r   <= cap_code_nxt;
    cap_a_r      <= cap_a_nxt;
    cap_b_r      <= cap_b_nxt;
    cap_byte_r   <= cap_byte_nxt;
    cur_r        <= cur_nxt;
    s_r          <= s_nxt;
    q_r          <= q_nxt;
    rraw_r       <= rraw_nxt;
    madr_r       <= madr_nxt;
    res_status_r <= res_status_nxt;
    res_ov_r     <= res_ov_nxt;
    res_ob_r     <= res_ob_nxt;
    o_status_r   <= o_status_nxt;
    o_ov_r       <= o_ov_nxt;
    o_ob_r       <= o_ob_nxt;
    o_pc_r       <= o_pc_nxt;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bf_ir_execute_unit.sv -----
`default_nettype none

// Brainfuck IR execution unit. Each input word either appends one
// instruction to the program store (load) or executes the instruction at the
// program counter (step), and each word yields exactly one result word. After
// reset the unit sweeps zeros through the data memory, one cell per cycle, so
// it takes no word until the sweep is done. After a word is taken, a load, a
// halted step, and add, const, in, out or a loop that falls through go
// straight to the result hand-off; a jumping loop or end loop adds a jump step;
// move adds the modulo steps; multiply-accumulate adds them, a read and a
// write-back. These extra steps come from the single read port of the data
// memory and from the pointer modulo, which multiplies by a constant
// reciprocal, subtracts and corrects once. The hand-off waits for a free output
// register; the next word is taken while the previous result still waits in it.
module bf_ir_execute_unit #(
  parameter int MEM_DEPTH  = 32768,
  parameter int PROG_DEPTH = 4096,
  parameter int LOOP_DEPTH = 1024
) (
  input  wire logic clk,
  input  wire logic rst_n,
  bfx_in_if.sink    in_ch,
  bfx_out_if.source out_ch
);

  bfx_pkg::cmd_t  cmd;
  bfx_pkg::stat_t stat;
  logic                             in_rdy;
  logic                             out_vld;
  logic [bfx_pkg::STATUS_W-1:0]     res_status;
  logic                             res_out_valid;
  logic [bfx_pkg::BYTE_W-1:0]       res_out_byte;
  logic [bfx_pkg::PC_OUT_W-1:0]     res_pc_now;

  assign in_ch.ready      = in_rdy;
  assign out_ch.valid     = out_vld;
  assign out_ch.status    = res_status;
  assign out_ch.out_valid = res_out_valid;
  assign out_ch.out_byte  = res_out_byte;
  assign out_ch.pc_now    = res_pc_now;

  bfx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_rdy),
    .out_valid (out_vld),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bfx_datapath #(
    .MEM_DEPTH  (MEM_DEPTH),
    .PROG_DEPTH (PROG_DEPTH),
    .LOOP_DEPTH (LOOP_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .pl_opcode    (in_ch.opcode),
    .pl_ir_code   (in_ch.ir_code),
    .pl_arg_a     (in_ch.arg_a),
    .pl_arg_b     (in_ch.arg_b),
    .pl_in_byte   (in_ch.in_byte),
    .pl_status    (res_status),
    .pl_out_valid (res_out_valid),
    .pl_out_byte  (res_out_byte),
    .pl_pc_now    (res_pc_now)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/bfx_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

// Port-level checks on the execution unit.
module bfx_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             out_vld,
  input wire logic                             out_rdy,
  input wire logic [bfx_pkg::STATUS_W-1:0]     status,
  input wire logic                             ov,
  input wire logic [bfx_pkg::BYTE_W-1:0]       ob,
  input wire logic [bfx_pkg::PC_OUT_W-1:0]     pc_now
);

  // Hold a stalled result word
  `BFX_ASSERT(a_out_hold, clk, rst_n, out_vld && !out_rdy |=> out_vld, "result word dropped")
  `BFX_ASSERT(a_out_stable, clk, rst_n, out_vld && !out_rdy |=> $stable(status) && $stable(ov) && $stable(ob) && $stable(pc_now), "stalled result word changed")

  // Reset empties the output register
  `BFX_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_vld, "result word after reset")

  // Only an executed output instruction carries a byte; status is a known code
  `BFX_ASSERT(a_byte_only_exec, clk, rst_n, out_vld && ov |-> status == bfx_pkg::ST_EXEC, "output byte on a non-executed word")
  `BFX_ASSERT(a_status_code, clk, rst_n, out_vld |-> status == bfx_pkg::ST_EXEC || status == bfx_pkg::ST_HALT || status == bfx_pkg::ST_LOAD, "unknown status code")

endmodule

bind bf_ir_execute_unit bfx_checker u_bfx_checker (
  .clk     (clk),
  .rst_n   (rst_n),
  .out_vld (out_ch.valid),
  .out_rdy (out_ch.ready),
  .status  (out_ch.status),
  .ov      (out_ch.out_valid),
  .ob      (out_ch.out_byte),
  .pc_now  (out_ch.pc_now)
);

`default_nettype wire
